[hdl/kmh_pkg.sv]
package kmh_pkg;

   localparam int MaxSources  = 16;
   localparam int AddrBits    = $clog2(MaxSources);
   localparam int PosBits     = AddrBits + 1;
   localparam int KeyBits     = 64;
   localparam int PayloadBits = 32;
   localparam int SourceBits  = 4;
   localparam int EntryBits   = KeyBits + PayloadBits + SourceBits;

   typedef enum logic [1:0] {
      REQ_PUSH    = 2'd0,
      REQ_REPLACE = 2'd1,
      REQ_POP     = 2'd2,
      REQ_NONE    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_PUSHED = 2'd0,
      ST_EMITTED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_code_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TOP_RD,
      S_TOP_WAIT,
      S_DN_RD,
      S_DN_CMP,
      S_TAIL_RD,
      S_TAIL_WAIT,
      S_UP_RD,
      S_UP_CMP,
      S_PUT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [KeyBits-1:0]     key;
      logic [PayloadBits-1:0] pay;
      logic [SourceBits-1:0]  src;
   } entry_type;

endpackage

[hdl/kmh_ram.sv]
module kmh_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   output logic [Width-1:0]         rd_data_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

[hdl/kway_merge_min_heap.sv]
// Channel   Direction  Ports
// req       in         req_valid, req_stall, req_type, new_key, new_payload, new_source
// rsp       out        rsp_valid, rsp_stall, status, out_key, out_payload, out_source,
//                      entries_left
// One word at a time. Push: the new entry climbs level by level from the new tail slot.
// Emit: read the top, descend the hole level by level, read the tail on a pop (unless the hole
// ends at the tail), then climb level by level.
// Synchronous active-high reset clears the count and control; RAM contents are not cleared.
// A stalled response is held in its output register while the next word is processed;
// that word's result waits in the final state until the register frees up.
module kway_merge_min_heap
   import kmh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_type,
   input  logic [KeyBits-1:0]     new_key,
   input  logic [PayloadBits-1:0] new_payload,
   input  logic [SourceBits-1:0]  new_source,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             status,
   output logic [KeyBits-1:0]     out_key,
   output logic [PayloadBits-1:0] out_payload,
   output logic [SourceBits-1:0]  out_source,
   output logic [PosBits-1:0]     entries_left
);

   state_type           state_ff, state_in;
   logic [PosBits-1:0]  count_ff, count_in;
   logic [PosBits-1:0]  pos_ff, pos_in;     // 1-based hole position
   logic [PosBits-1:0]  n_ff, n_in;         // heap size during descent
   logic [1:0]          req_ff, req_in;
   entry_type           ent_ff, ent_in;     // entry being placed
   entry_type           top_ff, top_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff, status_in;
   entry_type           rsp_ent_ff, rsp_ent_in;
   logic [PosBits-1:0]  left_ff, left_in;
   logic [1:0]          res_status_ff, res_status_in;
   entry_type           res_ent_ff, res_ent_in;
   logic [PosBits-1:0]  res_left_ff, res_left_in;

   logic                wr_en;
   logic [AddrBits-1:0] wr_addr, rd_addr_a, rd_addr_b;
   entry_type           wr_data, rd_a, rd_b;
   logic [PosBits:0]    child;
   logic                take_right;

   kmh_ram #(.Width(EntryBits), .Depth(MaxSources)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      n_ff          <= n_in;
      req_ff        <= req_in;
      ent_ff        <= ent_in;
      top_ff        <= top_in;
      status_ff     <= status_in;
      rsp_ent_ff    <= rsp_ent_in;
      left_ff       <= left_in;
      res_status_ff <= res_status_in;
      res_ent_ff    <= res_ent_in;
      res_left_ff   <= res_left_in;
   end

   assign child = {pos_ff, 1'b0};
   // tie: left child wins
   assign take_right = ({1'b0, child} + 1'b1 <= {2'b0, n_ff}) && (rd_a.key > rd_b.key);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      n_in          = n_ff;
      req_in        = req_ff;
      ent_in        = ent_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff;
      status_in     = status_ff;
      rsp_ent_in    = rsp_ent_ff;
      left_in       = left_ff;
      res_status_in = res_status_ff;
      res_ent_in    = res_ent_ff;
      res_left_in   = res_left_ff;
      wr_en         = 1'b0;
      wr_addr       = AddrBits'(pos_ff - 1'b1);
      wr_data       = ent_ff;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      req_stall     = 1'b1;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in     = req_type;
               ent_in     = '{key: new_key, pay: new_payload, src: new_source};
               res_ent_in = '0;
               case (req_type)
                  REQ_PUSH: begin
                     if (count_ff == PosBits'(MaxSources)) begin
                        res_status_in = ST_FULL;
                        res_left_in   = count_ff;
                        state_in      = S_RESP;
                     end else begin
                        pos_in   = count_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                        state_in = S_UP_RD;
                     end
                  end
                  REQ_REPLACE, REQ_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        res_left_in   = count_ff;
                        state_in      = S_RESP;
                     end else begin
                        n_in     = count_ff;
                        pos_in   = PosBits'(1);
                        state_in = S_TOP_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TOP_RD: begin
            rd_addr_a = '0;
            state_in  = S_TOP_WAIT;
         end
         S_TOP_WAIT: begin
            top_in   = rd_a;
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            if ({1'b0, child} > {2'b0, n_ff}) begin
               if (req_ff == REQ_REPLACE) begin
                  ent_in.src = top_ff.src;
                  state_in   = S_UP_RD;
               end else begin
                  count_in = n_ff - 1'b1;
                  state_in = (pos_ff == n_ff) ? S_RESP : S_TAIL_RD;
                  if (pos_ff == n_ff) begin
                     res_status_in = ST_EMITTED;
                     res_ent_in    = top_ff;
                     res_left_in   = n_ff - 1'b1;
                  end
               end
            end else begin
               rd_addr_a = AddrBits'(child - 1'b1);
               rd_addr_b = AddrBits'(child);
               state_in  = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en   = 1'b1;
            wr_data = take_right ? rd_b : rd_a;
            pos_in  = take_right ? PosBits'(child + 1'b1) : PosBits'(child);
            state_in = S_DN_RD;
         end
         S_TAIL_RD: begin
            rd_addr_a = AddrBits'(n_ff - 1'b1);
            state_in  = S_TAIL_WAIT;
         end
         S_TAIL_WAIT: begin
            ent_in   = rd_a;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            if (pos_ff == PosBits'(1)) begin
               state_in = S_PUT;
            end else begin
               rd_addr_a = AddrBits'((pos_ff >> 1) - 1'b1);
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (rd_a.key <= ent_ff.key) begin
               state_in = S_PUT;
            end else begin
               wr_en    = 1'b1;
               wr_data  = rd_a;
               pos_in   = pos_ff >> 1;
               state_in = S_UP_RD;
            end
         end
         S_PUT: begin
            wr_en       = 1'b1;
            wr_data     = ent_ff;
            res_left_in = count_ff;
            if (req_ff == REQ_PUSH) begin
               res_status_in = ST_PUSHED;
            end else begin
               res_status_in = ST_EMITTED;
               res_ent_in    = top_ff;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               status_in    = res_status_ff;
               rsp_ent_in   = res_ent_ff;
               left_in      = res_left_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign status       = status_ff;
   assign out_key      = rsp_ent_ff.key;
   assign out_payload  = rsp_ent_ff.pay;
   assign out_source   = rsp_ent_ff.src;
   assign entries_left = left_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PosBits'(MaxSources)) else $error("entry count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ent_ff))
      else $error("response dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("accept while busy");
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> pos_ff != '0) else $error("write at position zero");

endmodule
